// ----- rtl/hex_text_decoder_assert.svh -----
// Assertion macros used by the checker file of the hex text decoder.
`ifndef HEX_TEXT_DECODER_ASSERT_SVH
`define HEX_TEXT_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define HTD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hex_text_decoder assertion failed");

// Next-cycle implication, disabled while reset is high.
`define HTD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hex_text_decoder assertion failed");

`endif

// ----- rtl/htd_pkg.sv -----
package htd_pkg;

   localparam int unsigned MAX_LINE = 76;

   localparam logic [6:0] LINE_MAX   = 7'(MAX_LINE);
   localparam logic [6:0] COUNT_SAT  = 7'd127;

   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_TAB   = 8'd9;
   localparam logic [7:0] CHAR_VTAB  = 8'd11;

   localparam logic [1:0] CASE_LOWER = 2'd0;
   localparam logic [1:0] CASE_UPPER = 2'd2;

   localparam logic [1:0] REG_LINE_LIMIT = 2'd0;
   localparam logic [1:0] REG_CASE_MODE  = 2'd1;
   localparam logic [1:0] REG_STRIP      = 2'd2;

   localparam logic [6:0] RESET_LINE_LIMIT = 7'd0;
   localparam logic [1:0] RESET_CASE_MODE  = 2'd1;

   typedef enum logic [1:0] {
      PH_LEAD  = 2'd0,
      PH_CONT  = 2'd1,
      PH_TRAIL = 2'd2,
      PH_START = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BADCHAR = 2'd1,
      ST_LENGTH  = 2'd2,
      ST_ODD     = 2'd3
   } status_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } digit_type;

   function automatic digit_type digit_decode(input logic [7:0] c, input logic [1:0] case_mode);
      digit_type d;
      d.ok    = 1'b0;
      d.value = c[3:0];
      if (c >= 8'h30 && c <= 8'h39) begin
         d.ok = 1'b1;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d.ok    = (case_mode != CASE_LOWER);
         d.value = c[3:0] + 4'd9;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d.ok    = (case_mode != CASE_UPPER);
         d.value = c[3:0] + 4'd9;
      end
      return d;
   endfunction

endpackage

// ----- rtl/hex_text_decoder.sv -----
// Each accepted req beat goes through the input register, then the result register,
//   to its rsp beat; one rsp beat for every req beat.
// Throughput: one character per cycle, set by the single decode pass between the
//   two registers; a stalled rsp holds the result and then the input register.
// Reset: synchronous, active high; clears the line state, the sticky error and
//   returns the registers to line_limit 0, case_mode mixed, strip off.
module hex_text_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_in,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_byte_valid,
   output logic [7:0] rsp_byte_out,
   output logic [1:0] rsp_status,
   output logic       rsp_stream_done,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [6:0] csr_data
);

   // configuration
   logic [6:0] line_limit_ff;
   logic [1:0] case_mode_ff;
   logic       strip_ff;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_char_ff;
   logic       in_eot_ff;

   // line state
   htd_pkg::phase_type  phase_ff, phase_in;
   logic                pending_ff, pending_in;
   logic [3:0]          nibble_ff, nibble_in;
   logic                absorb_ff, absorb_in;
   logic [6:0]          count_ff, count_in;
   htd_pkg::status_type error_ff, error_in;

   // result register
   logic       out_valid_ff;
   logic       out_byte_valid_ff, out_byte_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic [1:0] out_status_ff;
   logic       out_done_ff;

   htd_pkg::status_type code;
   htd_pkg::phase_type  p;
   htd_pkg::digit_type  dig;
   logic [6:0]          lim;
   logic [6:0]          count_inc;
   logic                pair_done;
   logic                is_break;
   logic                is_blank;
   logic                out_free;
   logic                advance;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign csr_ready = 1'b1;

   assign lim       = (line_limit_ff > htd_pkg::LINE_MAX) ? htd_pkg::LINE_MAX : line_limit_ff;
   assign p         = (phase_ff == htd_pkg::PH_START) ?
                      (strip_ff ? htd_pkg::PH_LEAD : htd_pkg::PH_CONT) : phase_ff;
   assign dig       = htd_pkg::digit_decode(in_char_ff, case_mode_ff);
   assign count_inc = (count_ff == htd_pkg::COUNT_SAT) ? count_ff : count_ff + 7'd1;
   assign is_break  = (in_char_ff == htd_pkg::CHAR_LF) || (in_char_ff == htd_pkg::CHAR_CR);
   assign is_blank  = (in_char_ff == htd_pkg::CHAR_SPACE) || (in_char_ff == htd_pkg::CHAR_TAB) ||
                      (in_char_ff == htd_pkg::CHAR_VTAB);

   // next state of the line tracker and the status code
   always_comb begin
      phase_in   = phase_ff;
      pending_in = pending_ff;
      nibble_in  = nibble_ff;
      absorb_in  = absorb_ff;
      count_in   = count_ff;
      code       = htd_pkg::ST_OK;
      pair_done  = 1'b0;
      if (error_ff != htd_pkg::ST_OK) begin
         code = error_ff;
      end else begin
         if (pending_ff) begin
            if (!dig.ok) begin
               code = htd_pkg::ST_BADCHAR;
            end else begin
               pair_done  = 1'b1;
               pending_in = 1'b0;
               absorb_in  = 1'b0;
               phase_in   = htd_pkg::PH_CONT;
               count_in   = count_inc;
            end
         end else if (is_break) begin
            if (absorb_ff) begin
               absorb_in = 1'b0;
            end else if (lim != 7'd0 &&
                         (in_eot_ff ? (count_ff > lim) : (count_ff != lim))) begin
               code = htd_pkg::ST_LENGTH;
            end else if (p != htd_pkg::PH_CONT && p != htd_pkg::PH_TRAIL) begin
               code = htd_pkg::ST_BADCHAR;
            end else begin
               phase_in  = htd_pkg::PH_LEAD;
               absorb_in = 1'b1;
               count_in  = 7'd0;
            end
         end else begin
            absorb_in = 1'b0;
            if (is_blank) begin
               if (!strip_ff) begin
                  code = htd_pkg::ST_BADCHAR;
               end else begin
                  phase_in = (p == htd_pkg::PH_CONT) ? htd_pkg::PH_TRAIL : p;
               end
            end else if (p == htd_pkg::PH_TRAIL || !dig.ok) begin
               code = htd_pkg::ST_BADCHAR;
            end else begin
               nibble_in  = dig.value;
               pending_in = 1'b1;
               phase_in   = htd_pkg::PH_CONT;
               count_in   = count_inc;
            end
         end
         if (code == htd_pkg::ST_OK && in_eot_ff) begin
            if (pending_in) begin
               code = htd_pkg::ST_ODD;
            end else if (lim != 7'd0 && count_in > lim) begin
               code = htd_pkg::ST_LENGTH;
            end
         end
      end
      error_in = code;
      // end of stream: drop back to the reset state
      if (in_eot_ff) begin
         phase_in   = htd_pkg::PH_START;
         pending_in = 1'b0;
         nibble_in  = 4'd0;
         absorb_in  = 1'b0;
         count_in   = 7'd0;
         error_in   = htd_pkg::ST_OK;
      end
   end

   // result fields
   always_comb begin
      out_byte_valid_in = pair_done && (code == htd_pkg::ST_OK);
      out_byte_in       = out_byte_valid_in ? {nibble_ff, dig.value} : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_limit_ff <= htd_pkg::RESET_LINE_LIMIT;
         case_mode_ff  <= htd_pkg::RESET_CASE_MODE;
         strip_ff      <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            htd_pkg::REG_LINE_LIMIT: line_limit_ff <= csr_data;
            htd_pkg::REG_CASE_MODE:  case_mode_ff  <= csr_data[1:0];
            htd_pkg::REG_STRIP:      strip_ff      <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_char_ff <= req_char_in;
         in_eot_ff  <= req_end_of_text;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= htd_pkg::PH_START;
         pending_ff <= 1'b0;
         nibble_ff  <= 4'd0;
         absorb_ff  <= 1'b0;
         count_ff   <= 7'd0;
         error_ff   <= htd_pkg::ST_OK;
      end else if (advance) begin
         phase_ff   <= phase_in;
         pending_ff <= pending_in;
         nibble_ff  <= nibble_in;
         absorb_ff  <= absorb_in;
         count_ff   <= count_in;
         error_ff   <= error_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_byte_valid_ff <= out_byte_valid_in;
         out_byte_ff       <= out_byte_in;
         out_status_ff     <= code;
         out_done_ff       <= in_eot_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_byte_valid  = out_byte_valid_ff;
   assign rsp_byte_out    = out_byte_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_stream_done = out_done_ff;

endmodule

// ----- rtl/htd_checker.sv -----
`include "hex_text_decoder_assert.svh"

module htd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_char_in,
   input logic       req_end_of_text,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_byte_valid,
   input logic [7:0] rsp_byte_out,
   input logic [1:0] rsp_status,
   input logic       rsp_stream_done,
   input logic       csr_valid,
   input logic       csr_ready,
   input logic [1:0] csr_index,
   input logic [6:0] csr_data
);

   logic err_seen_ff;

   // track a sticky error seen on an earlier beat of the same stream
   always_ff @(posedge clock) begin
      if (reset) begin
         err_seen_ff <= 1'b0;
      end else if (rsp_valid && !rsp_stall) begin
         err_seen_ff <= (rsp_status != htd_pkg::ST_OK) && !rsp_stream_done;
      end
   end

   `HTD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_byte_out) && $stable(rsp_status) && $stable(rsp_byte_valid))
   `HTD_ASSERT_NOW(a_byte_zero, clock, reset, rsp_valid && !rsp_byte_valid, rsp_byte_out == 8'd0)
   `HTD_ASSERT_NOW(a_byte_ok, clock, reset, rsp_valid && rsp_byte_valid, rsp_status == htd_pkg::ST_OK)
   `HTD_ASSERT_NOW(a_sticky, clock, reset, rsp_valid && err_seen_ff, rsp_status != htd_pkg::ST_OK && !rsp_byte_valid)

endmodule

bind hex_text_decoder htd_checker u_htd_checker (.*);
